>>> src/hdst_pkg.sv
// Shared types and constants for the half-duplex serial transceiver.
package hdst_pkg;

   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned FrameBits   = 13;
   localparam int unsigned DataBits    = 8;

   localparam logic [CfgWidth-1:0] BitTicksReset  = 16'd3000;
   localparam logic [CfgWidth-1:0] WaitLimitReset = 16'd65500;

   localparam logic [CsrIdxWidth-1:0] CSR_BIT_TICKS  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_WAIT_LIMIT = 2'd1;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_SEND = 2'd1;
   localparam logic [1:0] REQ_RECV = 2'd2;

   typedef struct packed {
      logic       line_out;
      logic       drive_enable;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_done;
   } result_type;

endpackage

>>> src/hdst_core.sv
// Per-tick state update and result logic of the transceiver.
module hdst_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_accept,
   input  logic [1:0]            req_type,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_line_in,
   input  logic [15:0]           bit_ticks,
   input  logic [15:0]           wait_limit,
   output hdst_pkg::result_type  result
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SEND,
      PH_WAIT_HIGH,
      PH_WAIT_LOW,
      PH_SAMPLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [16:0] tick_ff, tick_in;
   logic [15:0] wait_ff, wait_in;
   logic [3:0]  bit_ff, bit_in;
   logic [12:0] shift_ff, shift_in;
   logic        drive_ff, drive_in;

   always_comb begin
      logic [16:0] tick_next;
      logic [16:0] target;
      logic [15:0] wait_next;
      logic [3:0]  bit_next;
      logic        awaited;
      logic        line;

      phase_in = phase_ff;
      tick_in  = tick_ff;
      wait_in  = wait_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      drive_in = drive_ff;
      line     = 1'b1;
      result   = '0;

      tick_next = '0;
      target    = '0;
      wait_next = '0;
      bit_next  = '0;
      awaited   = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (req_type == hdst_pkg::REQ_SEND) begin
            shift_in = {1'b1, ~req_tx_byte, 4'b1011};
            phase_in = PH_SEND;
            tick_in  = '0;
            bit_in   = '0;
            drive_in = 1'b1;
         end else if (req_type == hdst_pkg::REQ_RECV) begin
            phase_in = PH_WAIT_HIGH;
            wait_in  = '0;
            drive_in = 1'b0;
         end
      end

      result.busy_res = (phase_in != PH_IDLE);

      case (phase_in)
         PH_SEND: begin
            line      = shift_in[0];
            tick_next = tick_in + 17'd1;
            if (tick_next >= {1'b0, bit_ticks}) begin
               tick_in  = '0;
               shift_in = {1'b1, shift_in[12:1]};
               bit_next = bit_in + 4'd1;
               bit_in   = bit_next;
               if (bit_next >= 4'(hdst_pkg::FrameBits)) begin
                  phase_in       = PH_IDLE;
                  bit_in         = '0;
                  result.tx_done = 1'b1;
               end
            end else begin
               tick_in = tick_next;
            end
         end
         PH_WAIT_HIGH, PH_WAIT_LOW: begin
            awaited   = (phase_in == PH_WAIT_HIGH);
            wait_next = wait_in + 16'd1;
            if (req_line_in != awaited || wait_next >= wait_limit || wait_next == '0) begin
               wait_in = '0;
               if (phase_in == PH_WAIT_HIGH) begin
                  phase_in = PH_WAIT_LOW;
               end else begin
                  phase_in = PH_SAMPLE;
                  tick_in  = '0;
                  bit_in   = '0;
                  shift_in = '0;
               end
            end else begin
               wait_in = wait_next;
            end
         end
         PH_SAMPLE: begin
            target    = (bit_in == '0) ? ({1'b0, bit_ticks} + {2'b0, bit_ticks[15:1]})
                                       : {1'b0, bit_ticks};
            tick_next = tick_in + 17'd1;
            if (tick_next >= target) begin
               tick_in = '0;
               if (!req_line_in) begin
                  shift_in[bit_in[2:0]] = 1'b1;
               end
               bit_next = bit_in + 4'd1;
               bit_in   = bit_next;
               if (bit_next >= 4'(hdst_pkg::DataBits)) begin
                  phase_in        = PH_IDLE;
                  bit_in          = '0;
                  result.rx_valid = 1'b1;
                  result.rx_byte  = shift_in[7:0];
               end
            end else begin
               tick_in = tick_next;
            end
         end
         default: begin
         end
      endcase

      result.drive_enable = drive_in;
      result.line_out     = drive_in ? line : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         wait_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '1;
         drive_ff <= 1'b0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         drive_ff <= drive_in;
      end
   end

endmodule

>>> src/hdst_out_buf.sv
// Two-entry result buffer between the core and the result channel.
module hdst_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  hdst_pkg::result_type  push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output hdst_pkg::result_type  out_data
);

   hdst_pkg::result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/half_duplex_serial_transceiver.sv
// Top level of the half-duplex single-wire serial transceiver.
//
// Each request transaction is one timer tick: req_type (plain tick, start a
// send of req_tx_byte, start a receive) and the sampled line level req_line_in.
// A command while a send or receive runs is ignored.
// Every request yields exactly one response transaction carrying the line
// drive (rsp_line_out, rsp_drive_enable), rsp_busy_res, and the completion
// flags rsp_rx_valid/rsp_rx_byte and rsp_tx_done for that tick.
// Each response is registered in the response buffer before it is visible.
// Throughput: one tick per cycle while req_stall is low.
// A two-entry response buffer lets requests keep flowing while one response
// waits; req_stall rises only when both entries are held by a stalling
// receiver, and stalled responses hold steady.
// The csr port (csr_index 0: bit_ticks, 1: wait_limit) is always ready;
// other indexes are ignored. Write it only while idle.
// Reset (synchronous) returns to idle with the line released, empties the
// response buffer and restores bit_ticks 3000 and wait_limit 65500.
module half_duplex_serial_transceiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_line_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_out,
   output logic        rsp_drive_enable,
   output logic        rsp_busy_res,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_tx_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] bit_ticks_ff;
   logic [15:0] wait_limit_ff;
   logic        in_accept;
   logic        buf_full;
   hdst_pkg::result_type core_result;
   hdst_pkg::result_type out_result;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign in_accept = req_valid && !buf_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff  <= hdst_pkg::BitTicksReset;
         wait_limit_ff <= hdst_pkg::WaitLimitReset;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == hdst_pkg::CSR_BIT_TICKS) begin
            bit_ticks_ff <= csr_data;
         end else if (csr_index == hdst_pkg::CSR_WAIT_LIMIT) begin
            wait_limit_ff <= csr_data;
         end
      end
   end

   hdst_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .req_type    (req_type),
      .req_tx_byte (req_tx_byte),
      .req_line_in (req_line_in),
      .bit_ticks   (bit_ticks_ff),
      .wait_limit  (wait_limit_ff),
      .result      (core_result)
   );

   hdst_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (in_accept),
      .push_data (core_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_result)
   );

   assign rsp_line_out     = out_result.line_out;
   assign rsp_drive_enable = out_result.drive_enable;
   assign rsp_busy_res     = out_result.busy_res;
   assign rsp_rx_valid     = out_result.rx_valid;
   assign rsp_rx_byte      = out_result.rx_byte;
   assign rsp_tx_done      = out_result.tx_done;

endmodule

>>> src/hdst_checker.sv
// Port-level assertions for the transceiver and their bind.
module hdst_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_line_out,
   input logic        rsp_drive_enable,
   input logic        rsp_busy_res,
   input logic        rsp_rx_valid,
   input logic [7:0]  rsp_rx_byte,
   input logic        rsp_tx_done
);

   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_rx_valid && rsp_tx_done))
      else $error("rx and tx completion in one transaction");

   a_rx_released: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rx_valid) |-> (rsp_busy_res && !rsp_drive_enable))
      else $error("receive completion while line driven or not busy");

   a_tx_driven: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tx_done) |-> (rsp_busy_res && rsp_drive_enable && rsp_line_out))
      else $error("send completion without a driven stop bit");

   a_released_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_enable) |-> rsp_line_out)
      else $error("released line does not read high");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_rx_byte)))
      else $error("stalled response changed");

endmodule

bind half_duplex_serial_transceiver hdst_checker u_hdst_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the half-duplex serial transceiver: paced tick stimulus, scoreboard.
module tb_top;

   localparam logic [hdst_pkg::CsrIdxWidth-1:0] CSR_UNUSED = 2'd3;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int RandomTicks = 800;
   localparam int CycleLimit  = 200000;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SEND, PH_WAIT_HIGH, PH_WAIT_LOW, PH_SAMPLE
   } link_phase_type;

   class link_scoreboard;
      logic [hdst_pkg::CfgWidth-1:0] bit_ticks  = hdst_pkg::BitTicksReset;
      logic [hdst_pkg::CfgWidth-1:0] wait_limit = hdst_pkg::WaitLimitReset;
      link_phase_type phase = PH_IDLE;
      logic [16:0] tick_count = '0;
      logic [15:0] wait_count = '0;
      logic [3:0]  bit_index = '0;
      logic [12:0] shift_reg = '1;
      logic        drive_state = 1'b0;
      hdst_pkg::result_type expected[$];
      int          errors = 0;
      int          checked = 0;

      task report(string what);
         errors++;
         if (errors <= 30) $display("mismatch at response %0d: %s", checked, what);
      endtask

      function void set_register(logic [hdst_pkg::CsrIdxWidth-1:0] idx,
                                 logic [hdst_pkg::CfgWidth-1:0] data);
         if (idx == hdst_pkg::CSR_BIT_TICKS) bit_ticks = data;
         else if (idx == hdst_pkg::CSR_WAIT_LIMIT) wait_limit = data;
      endfunction

      function hdst_pkg::result_type predict_tick(logic [1:0] kind, logic [7:0] data,
                                                  logic level);
         hdst_pkg::result_type r;
         logic [16:0] target;
         logic awaited;
         r = '0;
         r.line_out = 1'b1;
         if (phase == PH_IDLE) begin
            if (kind == hdst_pkg::REQ_SEND) begin
               shift_reg = {1'b1, ~data, 1'b1, 1'b0, 1'b1, 1'b1};
               phase = PH_SEND;
               tick_count = '0;
               bit_index = '0;
               drive_state = 1'b1;
            end else if (kind == hdst_pkg::REQ_RECV) begin
               phase = PH_WAIT_HIGH;
               wait_count = '0;
               drive_state = 1'b0;
            end
         end
         r.busy_res = (phase != PH_IDLE);
         case (phase)
            PH_SEND: begin
               r.line_out = shift_reg[0];
               tick_count = tick_count + 17'd1;
               if (tick_count >= {1'b0, bit_ticks}) begin
                  tick_count = '0;
                  shift_reg = {1'b1, shift_reg[12:1]};
                  bit_index = bit_index + 4'd1;
                  if (bit_index >= 4'(hdst_pkg::FrameBits)) begin
                     phase = PH_IDLE;
                     bit_index = '0;
                     r.tx_done = 1'b1;
                  end
               end
            end
            PH_WAIT_HIGH, PH_WAIT_LOW: begin
               awaited = (phase == PH_WAIT_HIGH);
               wait_count = wait_count + 16'd1;
               if (level != awaited || wait_count >= wait_limit || wait_count == '0) begin
                  wait_count = '0;
                  if (phase == PH_WAIT_HIGH) begin
                     phase = PH_WAIT_LOW;
                  end else begin
                     phase = PH_SAMPLE;
                     tick_count = '0;
                     bit_index = '0;
                     shift_reg = '0;
                  end
               end
            end
            PH_SAMPLE: begin
               target = (bit_index == '0) ? {1'b0, bit_ticks} + {2'b0, bit_ticks[15:1]}
                                          : {1'b0, bit_ticks};
               tick_count = tick_count + 17'd1;
               if (tick_count >= target) begin
                  tick_count = '0;
                  if (!level) shift_reg[bit_index[2:0]] = 1'b1;
                  bit_index = bit_index + 4'd1;
                  if (bit_index >= 4'(hdst_pkg::DataBits)) begin
                     phase = PH_IDLE;
                     bit_index = '0;
                     r.rx_valid = 1'b1;
                     r.rx_byte = shift_reg[7:0];
                  end
               end
            end
            default: ;
         endcase
         if (!drive_state) r.line_out = 1'b1;
         r.drive_enable = drive_state;
         return r;
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] data, logic level);
         expected.push_back(predict_tick(kind, data, level));
      endfunction

      task check_response(hdst_pkg::result_type got);
         hdst_pkg::result_type want;
         checked++;
         if (expected.size() == 0) begin
            report("response with no request pending");
            return;
         end
         want = expected.pop_front();
         if (got.line_out != want.line_out)
            report($sformatf("line_out %b, predicted %b", got.line_out, want.line_out));
         if (got.drive_enable != want.drive_enable)
            report($sformatf("drive_enable %b, predicted %b", got.drive_enable,
                             want.drive_enable));
         if (got.busy_res != want.busy_res)
            report($sformatf("busy_res %b, predicted %b", got.busy_res, want.busy_res));
         if (got.rx_valid != want.rx_valid)
            report($sformatf("rx_valid %b, predicted %b", got.rx_valid, want.rx_valid));
         if (got.rx_byte != want.rx_byte)
            report($sformatf("rx_byte %h, predicted %h", got.rx_byte, want.rx_byte));
         if (got.tx_done != want.tx_done)
            report($sformatf("tx_done %b, predicted %b", got.tx_done, want.tx_done));
      endtask

      task report_leftovers();
         if (expected.size() != 0)
            report($sformatf("%0d responses never arrived", expected.size()));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_type = hdst_pkg::REQ_TICK;
   logic [7:0]                       req_tx_byte = '0;
   logic                             req_line_in = 1'b1;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b1;
   logic                             rsp_line_out;
   logic                             rsp_drive_enable;
   logic                             rsp_busy_res;
   logic                             rsp_rx_valid;
   logic [7:0]                       rsp_rx_byte;
   logic                             rsp_tx_done;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [hdst_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [hdst_pkg::CfgWidth-1:0]    csr_data = '0;

   link_scoreboard sb;
   bit req_idles = 1'b0;
   bit rsp_idles = 1'b0;
   int hold_cycles = 0;
   int ticks_driven = 0;
   int cycle_count = 0;

   half_duplex_serial_transceiver i_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_tx_byte, .req_line_in,
      .rsp_valid, .rsp_stall, .rsp_line_out, .rsp_drive_enable, .rsp_busy_res,
      .rsp_rx_valid, .rsp_rx_byte, .rsp_tx_done,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic drive_tick(input logic [1:0] kind, input logic [7:0] data, input logic level);
      int gap;
      gap = req_idles ? int'($urandom_range(0, 7)) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_tx_byte <= data;
      req_line_in <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, data, level);
      ticks_driven++;
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (sb.expected.size() != 0) @(posedge clock);
   endtask

   // random line, occasional (usually ignored) commands
   task automatic drain_to_idle();
      while (sb.phase != PH_IDLE)
         drive_tick(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3))
                                                : hdst_pkg::REQ_TICK,
                    8'($urandom), 1'($urandom));
   endtask

   task automatic write_reg(input logic [hdst_pkg::CsrIdxWidth-1:0] idx,
                            input logic [hdst_pkg::CfgWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic write_config(input logic [15:0] bt, input logic [15:0] wl, input bit poke_unused);
      drain_to_idle();
      wait_all_results();
      write_reg(hdst_pkg::CSR_BIT_TICKS, bt);
      write_reg(hdst_pkg::CSR_WAIT_LIMIT, wl);
      if (poke_unused) write_reg(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // line follows the receive state: edges for the waits, inverted data bits for samples
   task automatic run_recv(input logic [7:0] data, input bit noisy);
      bit   stuck;
      logic level;
      stuck = (sb.wait_limit <= 64) && ($urandom_range(0, 3) == 0);
      drive_tick(hdst_pkg::REQ_RECV, 8'($urandom), 1'($urandom));
      while (sb.phase != PH_IDLE) begin
         case (sb.phase)
            PH_WAIT_HIGH: level = stuck ? 1'b1 : ($urandom_range(0, 3) != 0);
            PH_WAIT_LOW:  level = stuck ? 1'b0 : ($urandom_range(0, 3) == 0);
            PH_SAMPLE:    level = ~data[sb.bit_index[2:0]];
            default:      level = 1'b1;
         endcase
         if (noisy) level = 1'($urandom_range(0, 1));
         drive_tick(($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3))
                                                 : hdst_pkg::REQ_TICK,
                    8'($urandom), level);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_line_out, rsp_drive_enable, rsp_busy_res, rsp_rx_valid,
                            rsp_rx_byte, rsp_tx_done});
   end

   initial begin : response_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = rsp_idles ? int'($urandom_range(0, 7)) : 0;
         repeat (gap) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] bt;
      logic [15:0] wl;
      bit first;
      int base;
      int phase_end;
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // plain and unknown ticks at reset settings
      drive_tick(hdst_pkg::REQ_TICK, 8'h00, 1'b0);
      drive_tick(REQ_UNKNOWN, 8'hFF, 1'b1);
      drive_tick(hdst_pkg::REQ_TICK, 8'hFF, 1'b1);
      drive_tick(REQ_UNKNOWN, 8'h00, 1'b0);

      // zero bit period and zero wait limit
      write_config(16'd0, 16'd0, 1'b0);
      drive_tick(hdst_pkg::REQ_SEND, 8'h00, 1'b0);
      drive_tick(hdst_pkg::REQ_RECV, 8'hFF, 1'b1);
      drive_tick(hdst_pkg::REQ_SEND, 8'hFF, 1'b0);
      drain_to_idle();
      run_recv(8'hFF, 1'b0);

      base = ticks_driven;
      first = 1'b1;
      while (ticks_driven - base < RandomTicks) begin
         case ($urandom_range(0, 4))
            0:       bt = 16'd0;
            1:       bt = 16'd1;
            2:       bt = 16'd2;
            default: bt = 16'($urandom_range(2, 12));
         endcase
         case ($urandom_range(0, 5))
            0:       wl = 16'd0;
            1:       wl = 16'd1;
            2:       wl = 16'hFFFF;
            3:       wl = hdst_pkg::WaitLimitReset;
            default: wl = 16'($urandom_range(1, 20));
         endcase
         write_config(bt, wl, first);
         req_idles = ($urandom_range(0, 2) != 0);
         rsp_idles = ($urandom_range(0, 2) != 0);
         if (first) hold_cycles = 80;
         first = 1'b0;
         phase_end = ticks_driven + 150;
         while (ticks_driven < phase_end) begin
            case ($urandom_range(0, 4))
               0, 1: begin
                  drive_tick(hdst_pkg::REQ_SEND, 8'($urandom), 1'($urandom));
                  drain_to_idle();
               end
               2, 3: run_recv(8'($urandom), $urandom_range(0, 4) == 0);
               default: begin
                  repeat ($urandom_range(1, 8))
                     drive_tick(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                  drain_to_idle();
               end
            endcase
         end
      end

      // longest periods: a send that runs past the end of stimulus
      write_config(16'hFFFF, 16'hFFFF, 1'b0);
      drive_tick(hdst_pkg::REQ_SEND, 8'hA5, 1'b1);
      repeat (300)
         drive_tick(($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 2))
                                                 : hdst_pkg::REQ_TICK,
                    8'($urandom), 1'($urandom));

      wait_all_results();
      repeat (4) @(posedge clock);
      sb.report_leftovers();
      if (sb.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

>>> sim.f
src/hdst_pkg.sv
src/hdst_core.sv
src/hdst_out_buf.sv
src/half_duplex_serial_transceiver.sv
src/hdst_checker.sv
tb/tb_top.sv
